// ----- rtl/clrq_pkg.sv -----
// ----------------------------------------------------------------------------
// Upper-bound rank store: shared package
// Sizes, command codes and the link record passed between neighboring cells.
// ----------------------------------------------------------------------------
package clrq_pkg;

  localparam int CAPACITY = 256;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 9;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int BIT_W    = (CNT_W > 2) ? $clog2(CNT_W) : 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic                      valid;
    logic                      le;
    logic signed [VALUE_W-1:0] value;
  } link_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } ctl_t;

endpackage

// ----- rtl/clrq_cell.sv -----
// ----------------------------------------------------------------------------
// Upper-bound rank store: storage cell
// Holds one value, compares it with the broadcast key and, on an insert,
// keeps its value, takes the key or takes its left neighbor's value.
// ----------------------------------------------------------------------------
module clrq_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  clrq_pkg::ctl_t                     ctl,
  input  logic signed [clrq_pkg::VALUE_W-1:0] key,
  input  clrq_pkg::link_t                    prev,
  output clrq_pkg::link_t                    link
);
  import clrq_pkg::*;

  logic                      valid_r;
  logic                      valid_nxt;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  logic                      le;

  assign le = valid_r && (value_r <= key);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift && !le) begin
      if (prev.le) begin
        valid_nxt = 1'b1;
        value_nxt = key;
      end else begin
        valid_nxt = prev.valid;
        value_nxt = prev.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign link.valid = valid_r;
  assign link.le    = le;
  assign link.value = value_r;

endmodule

// ----- rtl/count_less_or_equal_rank_query_top.sv -----
// ----------------------------------------------------------------------------
// Upper-bound rank store: top level
// Keeps signed values sorted in a row of cells and answers insert, rank
// query and clear items.
//
//   Port group   Direction  Contents
//   in_*         input      command, value; valid/ready
//   out_*        output     count, overflow; valid/ready
//
// One item is in work at a time. Insert, clear and the unused code pass
// through the execute and done states before their result is registered,
// and the next item is taken once the block is back in idle; a query also
// passes the search state, which finds one result bit per cycle of the rank
// search over the registered compare vector. Reset empties the store at once.
// A result that is not taken holds the block before the next is loaded.
// ----------------------------------------------------------------------------
module count_less_or_equal_rank_query_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic signed [clrq_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [clrq_pkg::COUNT_W-1:0]        out_count,
  output logic                                out_overflow
);
  import clrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [1:0]                cmd_r, cmd_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          rank_r, rank_nxt;
  logic [BIT_W-1:0]          bit_r, bit_nxt;
  logic [CAPACITY-1:0]       le_r, le_nxt;
  logic [CNT_W-1:0]          res_r, res_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  ctl_t                      ctl;
  link_t                     links [CAPACITY+1];
  logic [CAPACITY-1:0]       le_vec;
  logic [CNT_W-1:0]          cand;
  logic [CNT_W-1:0]          cand_m1;
  logic                      cand_ok;
  logic                      full;

  assign links[0].valid = 1'b1;
  assign links[0].le    = 1'b1;
  assign links[0].value = key_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    clrq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .key   (key_r),
      .prev  (links[i]),
      .link  (links[i+1])
    );
    assign le_vec[i] = links[i+1].le;
  end

  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign cand    = rank_r | (CNT_W'(1) << bit_r);
  assign cand_m1 = cand - CNT_W'(1);
  assign cand_ok = (cand <= CNT_W'(CAPACITY)) && le_r[cand_m1[IDX_W-1:0]];

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    rank_nxt      = rank_r;
    bit_nxt       = bit_r;
    le_nxt        = le_r;
    res_nxt       = res_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    ctl.shift     = 1'b0;
    ctl.clear     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          key_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ovf_nxt   = 1'b0;
        res_nxt   = cnt_r;
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_INSERT: begin
            if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              ctl.shift = 1'b1;
              cnt_nxt   = cnt_r + CNT_W'(1);
              res_nxt   = cnt_r + CNT_W'(1);
            end
          end
          CMD_QUERY: begin
            le_nxt    = le_vec;
            rank_nxt  = '0;
            bit_nxt   = BIT_W'(CNT_W - 1);
            state_nxt = S_SEARCH;
          end
          CMD_CLEAR: begin
            ctl.clear = 1'b1;
            cnt_nxt   = '0;
            res_nxt   = '0;
          end
          default: begin
            res_nxt = cnt_r;
          end
        endcase
      end
      S_SEARCH: begin
        if (cand_ok) begin
          rank_nxt = cand;
        end
        if (bit_r == '0) begin
          res_nxt   = cand_ok ? cand : rank_r;
          state_nxt = S_DONE;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = COUNT_W'(res_r);
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    rank_r      <= rank_nxt;
    bit_r       <= bit_nxt;
    le_r        <= le_nxt;
    res_r       <= res_nxt;
    ovf_r       <= ovf_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_count    = out_count_r;
  assign out_overflow = out_ovf_r;

endmodule

// ----- verif/clrq_checker.sv -----
// ----------------------------------------------------------------------------
// Upper-bound rank store: result checker
// Watches both channels of the rank store, keeps its own copy of the stored
// values, predicts the count and overflow flag of every accepted item and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module clrq_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic signed [clrq_pkg::VALUE_W-1:0] in_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [clrq_pkg::COUNT_W-1:0]        out_count,
  input  logic                                out_overflow,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked,
  output int                                  drops,
  output int                                  peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import clrq_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } rank_answer_t;

  logic signed [VALUE_W-1:0] held_values[$];
  rank_answer_t              answers_due[$];
  int                        err_total = 0;
  int                        result_total = 0;
  int                        drop_total = 0;
  int                        fill_peak = 0;

  assign errors    = err_total;
  assign pending   = answers_due.size();
  assign checked   = result_total;
  assign drops     = drop_total;
  assign peak_fill = fill_peak;

  function automatic rank_answer_t predict_rank(input logic [1:0] cmd,
                                                input logic signed [VALUE_W-1:0] val);
    rank_answer_t ans;
    int           not_above;
    ans.overflow = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          ans.overflow = 1'b1;
          drop_total++;
        end else begin
          held_values = {held_values, val};
        end
        ans.count = COUNT_W'(held_values.size());
        if (held_values.size() > fill_peak) fill_peak = held_values.size();
      end
      CMD_QUERY: begin
        not_above = 0;
        foreach (held_values[i]) if (held_values[i] <= val) not_above++;
        ans.count = COUNT_W'(not_above);
      end
      CMD_CLEAR: begin
        held_values.delete();
        ans.count = '0;
      end
      default: begin
        ans.count = COUNT_W'(held_values.size());
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    rank_answer_t due;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        result_total++;
        if (answers_due.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("%0t: result with no item pending: count %0d overflow %0b",
                     $realtime, out_count, out_overflow);
        end else begin
          due = answers_due.pop_front();
          if (out_count !== due.count || out_overflow !== due.overflow) begin
            err_total++;
            if (err_total <= 10)
              $display({"%0t: result %0d mismatch: count exp %0d got %0d, ",
                        "overflow exp %0b got %0b"},
                       $realtime, result_total, due.count, out_count,
                       due.overflow, out_overflow);
          end
        end
      end
      if (in_valid && in_ready)
        answers_due = {answers_due, predict_rank(in_command, in_value)};
    end
  end

endmodule

// ----- verif/count_less_or_equal_rank_query_top_tb.sv -----
// ----------------------------------------------------------------------------
// Upper-bound rank store: testbench top
// Drives insert, query, clear and unused-code items into the store: a short
// directed run over the value extremes, then a fill past capacity and a
// random mix, with random idling on both sides and long output stalls.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module count_less_or_equal_rank_query_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clrq_pkg::*;

  localparam int         ITEM_TARGET = 650;
  localparam int         HOLD_CYCLES = 200;
  localparam int         CYCLE_LIMIT = 200000;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_command = CMD_INSERT;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_overflow;

  int errors;
  int pending;
  int checked;
  int drops;
  int peak_fill;

  logic                      calm = 1'b0;
  int                        hold_ticket = 0;
  int                        hold_served = 0;
  int                        hold_left = 0;
  int                        cycle_count = 0;
  int                        sent_total = 0;
  int                        sent_by_cmd[4] = '{0, 0, 0, 0};
  logic signed [VALUE_W-1:0] stored_mirror[$];

  count_less_or_equal_rank_query_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_count    (out_count),
    .out_overflow (out_overflow)
  );

  clrq_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_count    (out_count),
    .out_overflow (out_overflow),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .drops        (drops),
    .peak_fill    (peak_fill)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_ticket;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] val);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
    sent_by_cmd[cmd]++;
    if (cmd == CMD_INSERT && stored_mirror.size() < CAPACITY)
      stored_mirror = {stored_mirror, val};
    if (cmd == CMD_CLEAR) stored_mirror.delete();
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom();
    if (sel < 70) return $signed(32'($urandom_range(16))) - 8;
    if (sel < 94 && stored_mirror.size() != 0)
      return stored_mirror[$urandom_range(stored_mirror.size() - 1)]
             + ($signed(32'($urandom_range(2))) - 1);
    if (sel < 97) return 32'sh8000_0000 + $signed(32'($urandom_range(1)));
    return 32'sh7FFF_FFFF - $signed(32'($urandom_range(1)));
  endfunction

  initial begin
    int i;
    int sel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_QUERY,  32'sh0000_0000);
    send_item(CMD_INSERT, 32'sh7FFF_FFFF);
    send_item(CMD_INSERT, 32'sh8000_0000);
    send_item(CMD_INSERT, 32'sh0000_0000);
    send_item(CMD_INSERT, -32'sd1);
    send_item(CMD_INSERT, 32'sh0000_0000);
    send_item(CMD_INSERT, 32'sh0000_0001);
    send_item(CMD_QUERY,  32'sh8000_0000);
    send_item(CMD_QUERY,  32'sh8000_0001);
    send_item(CMD_QUERY,  -32'sd1);
    send_item(CMD_QUERY,  32'sh0000_0000);
    send_item(CMD_QUERY,  32'sh7FFF_FFFE);
    send_item(CMD_QUERY,  32'sh7FFF_FFFF);
    send_item(CMD_UNUSED, 32'sh5555_AAAA);
    send_item(CMD_CLEAR,  32'shAAAA_5555);
    send_item(CMD_QUERY,  32'sh7FFF_FFFF);
    send_item(CMD_UNUSED, 32'sh0000_0000);
    send_item(CMD_INSERT, 32'sh1234_5678);
    send_item(CMD_QUERY,  32'sh1234_5677);
    send_item(CMD_CLEAR,  -32'sd1);

    i = 0;
    while (stored_mirror.size() < CAPACITY || sent_by_cmd[CMD_INSERT] < CAPACITY + 8) begin
      if (i == 40) hold_ticket <= hold_ticket + 1;
      if (stored_mirror.size() == 100) calm <= 1'b1;
      if (stored_mirror.size() == 180) calm <= 1'b0;
      if ($urandom_range(99) < 70) send_item(CMD_INSERT, pick_value());
      else send_item(CMD_QUERY, pick_value());
      i++;
    end
    calm <= 1'b0;
    send_item(CMD_QUERY, 32'sh7FFF_FFFF);
    send_item(CMD_UNUSED, pick_value());
    send_item(CMD_CLEAR, pick_value());

    i = 0;
    while (sent_total < ITEM_TARGET) begin
      if (i == 60) hold_ticket <= hold_ticket + 1;
      sel = $urandom_range(99);
      if (sel < 44) send_item(CMD_INSERT, pick_value());
      else if (sel < 88) send_item(CMD_QUERY, pick_value());
      else if (sel < 94) send_item(CMD_CLEAR, pick_value());
      else send_item(CMD_UNUSED, pick_value());
      i++;
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d items: %0d insert, %0d query, %0d clear, %0d unused code",
             sent_total, sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_QUERY],
             sent_by_cmd[CMD_CLEAR], sent_by_cmd[CMD_UNUSED]);
    $display("Checked %0d results, %0d dropped inserts, store filled to %0d of %0d, %0d errors",
             checked, drops, peak_fill, CAPACITY, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/clrq_pkg.sv
rtl/clrq_cell.sv
rtl/count_less_or_equal_rank_query_top.sv
verif/clrq_checker.sv
verif/count_less_or_equal_rank_query_top_tb.sv
